// ===== rtl/esc_pkg.sv =====
// shared types, character codes, rule numbers and helpers of the expression syntax checker
package esc_pkg;

  localparam int unsigned NUM_RULES = 27;
  localparam int unsigned COUNT_W   = 13;
  localparam int unsigned DOT_W     = 2;
  localparam int unsigned SLOTS     = 4;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
  localparam logic [DOT_W-1:0]   DOT_MAX   = {DOT_W{1'b1}};

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_A     = 8'h61;
  localparam logic [7:0] CH_Z     = 8'h7a;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_STAR  = 8'h2a;
  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [7:0] CH_CARET = 8'h5e;
  localparam logic [7:0] CH_DOT   = 8'h2e;
  localparam logic [7:0] CH_LP    = 8'h28;
  localparam logic [7:0] CH_RP    = 8'h29;

  typedef enum logic [4:0] {
    R_CHAR     = 5'd0,
    R_DG_LT    = 5'd1,
    R_DG_LP    = 5'd2,
    R_PT_PT    = 5'd3,
    R_PT_OP    = 5'd4,
    R_PT_LT    = 5'd5,
    R_PT_LP    = 5'd6,
    R_PT_RP    = 5'd7,
    R_OP_PT    = 5'd8,
    R_OP_OP    = 5'd9,
    R_OP_RP    = 5'd10,
    R_LT_DG    = 5'd11,
    R_LT_PT    = 5'd12,
    R_LP_PT    = 5'd13,
    R_LP_OP    = 5'd14,
    R_LP_RP    = 5'd15,
    R_RP_DG    = 5'd16,
    R_RP_PT    = 5'd17,
    R_RP_LT    = 5'd18,
    R_RP_LP    = 5'd19,
    R_LT_LT    = 5'd20,
    R_UNBAL    = 5'd21,
    R_DOTS     = 5'd22,
    R_EARLY_RP = 5'd23,
    R_OP_FIRST = 5'd24,
    R_OP_LAST  = 5'd25,
    R_LT_LP    = 5'd26
  } rule_e;

  typedef struct packed {
    logic op;
    logic dg;
    logic lt;
    logic pt;
    logic lp;
    logic rp;
  } cls_t;

  // function heads that get rewritten to a+( when followed by an open paren
  localparam logic [23:0] FN_HEADS [12] = '{
    24'h73656e, 24'h636f73, 24'h74616e, 24'h616273,
    24'h61736e, 24'h616373, 24'h61746e, 24'h6c6f67,
    24'h636569, 24'h657870, 24'h737172, 24'h726362
  };

  function automatic cls_t classify(logic [7:0] c);
    cls_t r;
    r.op = (c == CH_PLUS) || (c == CH_MINUS) || (c == CH_STAR) ||
           (c == CH_SLASH) || (c == CH_CARET);
    r.dg = (c >= CH_0) && (c <= CH_9);
    r.lt = (c >= CH_A) && (c <= CH_Z);
    r.pt = (c == CH_DOT);
    r.lp = (c == CH_LP);
    r.rp = (c == CH_RP);
    return r;
  endfunction

  function automatic logic is_head(logic [7:0] c0, logic [7:0] c1, logic [7:0] c2);
    logic hit;
    hit = 1'b0;
    for (int i = 0; i < 12; i++) begin
      hit = hit | ({c0, c1, c2} == FN_HEADS[i]);
    end
    return hit;
  endfunction

endpackage

// ===== rtl/expression_syntax_checker.sv =====
// top level of the streaming expression syntax checker
//
//  channel  direction  handshake                 payload
//  input    in         in_valid_i / in_stall_o   char_code_i, last_i
//  result   out        out_valid_o / out_stall_i valid_res_o, first_error_o, fail_mask_o
//
// one item per cycle while the input is not stalled; an item waits in the input
// register, and the verdict of a last item moves from there into the result register.
// all rule work for an item (window rewrite, up to four characters checked,
// counters) sits between the input register and the result register.
// input stalls only while a last item waits for a result register that is full.
// reset clears the window count, counters and collected failures.
module expression_syntax_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [7:0]                    char_code_i,
  input  logic                          last_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          valid_res_o,
  output logic [4:0]                    first_error_o,
  output logic [esc_pkg::NUM_RULES-1:0] fail_mask_o
);

  localparam int unsigned NR = esc_pkg::NUM_RULES;
  localparam int unsigned CW = esc_pkg::COUNT_W;
  localparam int unsigned NS = esc_pkg::SLOTS;

  // input register
  logic             s1_valid_q, s1_valid_d;
  logic [7:0]       s1_char_q;
  logic             s1_last_q;

  // checker state
  logic [7:0]       win_q [3];
  logic [7:0]       win_d [3];
  logic [1:0]       pcnt_q, pcnt_d;
  logic [7:0]       prev_q, prev_d;
  logic             seen_q, seen_d;
  logic [CW-1:0]    open_q, open_d;
  logic [CW-1:0]    close_q, close_d;
  logic [1:0]       dots_q, dots_d;
  logic [NR-1:0]    failed_q, failed_d;

  // result register
  logic             out_valid_q, out_valid_d;
  logic             res_ok_q, res_ok_d;
  logic [4:0]       res_first_q, res_first_d;
  logic [NR-1:0]    res_mask_q, res_mask_d;

  logic             accept;
  logic             go;
  logic             head;
  logic [1:0]       npcnt;
  logic [7:0]       slot [NS];
  logic [NS-1:0]    slot_v;
  logic [7:0]       pch [NS+1];
  logic             psn [NS+1];
  logic [NR-1:0]    rf [NS];

  assign go         = s1_valid_q && (!s1_last_q || !out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !go;
  assign accept     = in_valid_i && !in_stall_o;

  // window rewrite: decide which characters reach the rules in this item
  always_comb begin
    head = (s1_char_q == esc_pkg::CH_LP) && (pcnt_q == 2'd3) &&
           esc_pkg::is_head(win_q[0], win_q[1], win_q[2]);
    win_d  = win_q;
    npcnt  = pcnt_q;
    slot   = '{default: esc_pkg::CH_NUL};
    slot_v = '0;
    if (head) begin
      slot[0] = esc_pkg::CH_A;
      slot[1] = esc_pkg::CH_PLUS;
      slot[2] = esc_pkg::CH_LP;
      slot_v  = 4'b0111;
      npcnt   = 2'd0;
    end else if (pcnt_q == 2'd3) begin
      slot[0]   = win_q[0];
      slot_v[0] = 1'b1;
      win_d[0]  = win_q[1];
      win_d[1]  = win_q[2];
      win_d[2]  = s1_char_q;
    end else begin
      win_d[pcnt_q] = s1_char_q;
      npcnt = pcnt_q + 2'd1;
    end
    // flush the window on the last item
    if (s1_last_q && !head) begin
      if (pcnt_q == 2'd3) begin
        slot[1] = win_d[0];
        slot[2] = win_d[1];
        slot[3] = win_d[2];
        slot_v  = 4'b1111;
      end else begin
        for (int i = 0; i < 3; i++) begin
          slot[i]   = win_d[i];
          slot_v[i] = 2'(i) < npcnt;
        end
      end
    end
  end

  // previous character and seen flag as seen by each slot
  always_comb begin
    pch[0] = prev_q;
    psn[0] = seen_q;
    for (int k = 0; k < NS; k++) begin
      pch[k+1] = slot_v[k] ? slot[k] : pch[k];
      psn[k+1] = slot_v[k] | psn[k];
    end
  end

  for (genvar k = 0; k < NS; k++) begin : g_rules
    esc_rules u_rules (
      .char_i (slot[k]),
      .prev_i (pch[k]),
      .seen_i (psn[k]),
      .fail_o (rf[k])
    );
  end

  // counters and collected failures
  always_comb begin
    esc_pkg::cls_t cls;
    logic [2:0]    n_open;
    logic [2:0]    n_close;
    logic [CW:0]   sum_o;
    logic [CW:0]   sum_c;
    logic [CW-1:0] open_k;
    logic [CW-1:0] close_k;
    logic [1:0]    dots;
    logic [NR-1:0] acc;
    logic [NR-1:0] verdict;

    n_open  = '0;
    n_close = '0;
    open_k  = open_q;
    close_k = close_q;
    dots    = dots_q;
    acc     = failed_q;
    for (int k = 0; k < NS; k++) begin
      cls = esc_pkg::classify(slot[k]);
      if (slot_v[k]) begin
        n_open  = n_open + 3'(cls.lp);
        n_close = n_close + 3'(cls.rp);
        if (cls.op) begin
          dots = '0;
        end
        if (cls.pt && dots < esc_pkg::DOT_MAX) begin
          dots = dots + 2'd1;
        end
      end
      // saturating count after this slot, computed from the item start
      sum_o   = {1'b0, open_q} + (CW+1)'(n_open);
      sum_c   = {1'b0, close_q} + (CW+1)'(n_close);
      open_k  = (sum_o > {1'b0, esc_pkg::COUNT_MAX}) ? esc_pkg::COUNT_MAX : sum_o[CW-1:0];
      close_k = (sum_c > {1'b0, esc_pkg::COUNT_MAX}) ? esc_pkg::COUNT_MAX : sum_c[CW-1:0];
      if (slot_v[k]) begin
        acc = acc | rf[k];
        acc[esc_pkg::R_EARLY_RP] = acc[esc_pkg::R_EARLY_RP] | (close_k > open_k);
        acc[esc_pkg::R_DOTS]     = acc[esc_pkg::R_DOTS] | (dots > 2'd1);
      end
    end

    cls = esc_pkg::classify(pch[NS]);
    verdict = acc;
    verdict[esc_pkg::R_UNBAL]   = acc[esc_pkg::R_UNBAL] | (open_k != close_k);
    verdict[esc_pkg::R_OP_LAST] = acc[esc_pkg::R_OP_LAST] | (psn[NS] && cls.op);

    res_first_d = '0;
    for (int k = NR - 1; k >= 0; k--) begin
      if (verdict[k]) begin
        res_first_d = 5'(k + 1);
      end
    end
    res_mask_d = verdict;
    res_ok_d   = (verdict == '0);

    if (s1_last_q) begin
      pcnt_d   = '0;
      prev_d   = esc_pkg::CH_NUL;
      seen_d   = 1'b0;
      open_d   = '0;
      close_d  = '0;
      dots_d   = '0;
      failed_d = '0;
    end else begin
      pcnt_d   = npcnt;
      prev_d   = pch[NS];
      seen_d   = psn[NS];
      open_d   = open_k;
      close_d  = close_k;
      dots_d   = dots;
      failed_d = acc;
    end
  end

  always_comb begin
    s1_valid_d = accept ? 1'b1 : (go ? 1'b0 : s1_valid_q);
    if (go && s1_last_q) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      pcnt_q      <= '0;
      prev_q      <= esc_pkg::CH_NUL;
      seen_q      <= 1'b0;
      open_q      <= '0;
      close_q     <= '0;
      dots_q      <= '0;
      failed_q    <= '0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (go) begin
        pcnt_q   <= pcnt_d;
        prev_q   <= prev_d;
        seen_q   <= seen_d;
        open_q   <= open_d;
        close_q  <= close_d;
        dots_q   <= dots_d;
        failed_q <= failed_d;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_char_q <= char_code_i;
      s1_last_q <= last_i;
    end
    if (go) begin
      win_q <= win_d;
    end
    if (go && s1_last_q) begin
      res_ok_q    <= res_ok_d;
      res_first_q <= res_first_d;
      res_mask_q  <= res_mask_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign valid_res_o   = res_ok_q;
  assign first_error_o = res_first_q;
  assign fail_mask_o   = res_mask_q;

  // a processed last item always lands in the result register
  a_last_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (go && s1_last_q) |=> out_valid_q)
    else $error("last item did not produce a result");

  // an item never waits when the result register is free
  a_no_needless_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !out_valid_q) |-> !in_stall_o)
    else $error("input stalled with an empty result register");

  // verdict fields agree with each other
  a_verdict_consistent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (res_ok_q == (res_first_q == 5'd0)))
    else $error("verdict flag and first failed rule disagree");

  // counters are cleared once a verdict has been registered
  a_state_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (go && s1_last_q) |=> (open_q == '0 && close_q == '0 && pcnt_q == 2'd0 && !seen_q))
    else $error("state not cleared after verdict");

endmodule

// ===== rtl/esc_rules.sv =====
// per-character and adjacent-pair rule checks for one character of the rewritten stream
module esc_rules (
  input  logic [7:0]                       char_i,
  input  logic [7:0]                       prev_i,
  input  logic                             seen_i,
  output logic [esc_pkg::NUM_RULES-1:0]    fail_o
);

  esc_pkg::cls_t c;
  esc_pkg::cls_t p;

  always_comb begin
    c = esc_pkg::classify(char_i);
    p = esc_pkg::classify(prev_i);
    fail_o = '0;
    fail_o[esc_pkg::R_CHAR] = !(c.op || c.dg || c.lt || c.pt || c.lp || c.rp);
    if (seen_i) begin
      fail_o[esc_pkg::R_DG_LT] = p.dg && c.lt;
      fail_o[esc_pkg::R_DG_LP] = p.dg && c.lp;
      fail_o[esc_pkg::R_PT_PT] = p.pt && c.pt;
      fail_o[esc_pkg::R_PT_OP] = p.pt && c.op;
      fail_o[esc_pkg::R_PT_LT] = p.pt && c.lt;
      fail_o[esc_pkg::R_PT_LP] = p.pt && c.lp;
      fail_o[esc_pkg::R_PT_RP] = p.pt && c.rp;
      fail_o[esc_pkg::R_OP_PT] = p.op && c.pt;
      fail_o[esc_pkg::R_OP_OP] = p.op && c.op;
      fail_o[esc_pkg::R_OP_RP] = p.op && c.rp;
      fail_o[esc_pkg::R_LT_DG] = p.lt && c.dg;
      fail_o[esc_pkg::R_LT_PT] = p.lt && c.pt;
      fail_o[esc_pkg::R_LT_LT] = p.lt && c.lt;
      fail_o[esc_pkg::R_LT_LP] = p.lt && c.lp;
      fail_o[esc_pkg::R_LP_PT] = p.lp && c.pt;
      fail_o[esc_pkg::R_LP_OP] = p.lp && c.op;
      fail_o[esc_pkg::R_LP_RP] = p.lp && c.rp;
      fail_o[esc_pkg::R_RP_DG] = p.rp && c.dg;
      fail_o[esc_pkg::R_RP_PT] = p.rp && c.pt;
      fail_o[esc_pkg::R_RP_LT] = p.rp && c.lt;
      fail_o[esc_pkg::R_RP_LP] = p.rp && c.lp;
    end else begin
      fail_o[esc_pkg::R_OP_FIRST] = c.op;
    end
  end

endmodule
